>>> hw/rtl/tfn_pkg.sv
// tfn_pkg: shared constants, types and width helpers for the triangle face normal block
// no dependencies; used by every module under hw/rtl
package tfn_pkg;

    localparam int OUT_W      = 16;                  // signed q1.14 normal component
    localparam int UNIT_ONE   = 16384;               // 1.0 in q1.14
    localparam int FRAC_SHIFT = 30;                  // quotient scale: c^2 * 2^30 / s
    localparam int QUOT_W     = FRAC_SHIFT + 1;
    localparam int RAD_W      = 32;                  // radicand for the root, quotient padded
    localparam int ROOT_W     = RAD_W / 2;
    localparam int REM_W      = ROOT_W + 2;
    localparam int THR_W      = 32;
    localparam logic [THR_W-1:0] THR_RESET = 32'd429;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    typedef struct packed {
        logic full;
        logic empty;
        logic room;      // a push can be taken this cycle
    } fifo_stat_t;

    // squared length of one cross product component
    function automatic int csq_w(int cw);
        return 4 * cw + 2;
    endfunction

    // sum of three squared components
    function automatic int sum_w(int cw);
        return 4 * cw + 4;
    endfunction

    // front to back payload: three squares, sum, three signs, degenerate flag
    function automatic int payload_w(int cw);
        return 3 * csq_w(cw) + sum_w(cw) + 4;
    endfunction

endpackage

>>> hw/rtl/tfn_fifo.sv
// tfn_fifo: short queue between the geometry front end and the normalize back end
// depends on tfn_pkg
module tfn_fifo #(
    parameter int DATA_W = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  logic [DATA_W-1:0]    push_data,
    input  logic                 pop,
    output logic [DATA_W-1:0]    pop_data,
    output tfn_pkg::fifo_stat_t  stat
);

    localparam int AW = tfn_pkg::FIFO_AW;

    logic [DATA_W-1:0] fifo_mem_reg [0:tfn_pkg::FIFO_DEPTH-1];
    logic [AW-1:0]     wr_ptr_reg;
    logic [AW-1:0]     rd_ptr_reg;
    logic [AW:0]       count_reg;
    logic [AW:0]       count_next;

    assign stat.full  = (count_reg == (AW+1)'(tfn_pkg::FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.room  = !stat.full || pop;
    assign pop_data   = fifo_mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!stat.full || pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !stat.empty)
        else $error("queue read while empty");

endmodule

>>> hw/rtl/tfn_front.sv
// tfn_front: edge vectors, cross product, squared length and degenerate test
// depends on tfn_pkg; feeds tfn_fifo
module tfn_front #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        in_valid,
    output logic                                        in_ready,
    input  logic [9*COORD_WIDTH-1:0]                    in_data,
    input  logic [tfn_pkg::THR_W-1:0]                   thr,
    input  tfn_pkg::fifo_stat_t                         stat,
    output logic                                        push,
    output logic [tfn_pkg::payload_w(COORD_WIDTH)-1:0]  push_data
);

    localparam int CW   = COORD_WIDTH;
    localparam int EW   = CW + 1;
    localparam int PW   = 2 * EW;
    localparam int DW   = PW + 1;
    localparam int MW   = 2 * CW + 1;
    localparam int HW   = (MW + 1) / 2;
    localparam int HIW  = MW - HW;
    localparam int CSW  = tfn_pkg::csq_w(CW);
    localparam int SW   = tfn_pkg::sum_w(CW);
    localparam int NSTG = 7;

    logic                 en;
    logic [NSTG-1:0]      v_reg;

    logic signed [EW-1:0] e1_reg [0:2];
    logic signed [EW-1:0] e2_reg [0:2];
    logic signed [EW-1:0] e1_next [0:2];
    logic signed [EW-1:0] e2_next [0:2];
    logic signed [PW-1:0] p_reg [0:5];
    logic signed [PW-1:0] p_next [0:5];
    logic [MW-1:0]        mag_reg [0:2];
    logic [MW-1:0]        mag_next [0:2];
    logic [2:0]           neg3_reg;
    logic [2:0]           neg3_next;
    logic [2*HIW-1:0]     hh_reg [0:2];
    logic [MW-1:0]        hl_reg [0:2];
    logic [2*HW-1:0]      ll_reg [0:2];
    logic [2:0]           neg4_reg;
    logic [CSW-1:0]       csq5_reg [0:2];
    logic [CSW-1:0]       csq5_next [0:2];
    logic [2:0]           neg5_reg;
    logic [CSW-1:0]       csq6_reg [0:2];
    logic [2:0]           neg6_reg;
    logic [SW-1:0]        s6_reg;
    logic [SW-1:0]        s6_next;
    logic [CSW-1:0]       csq7_reg [0:2];
    logic [2:0]           neg7_reg;
    logic [SW-1:0]        s7_reg;
    logic                 deg7_reg;
    logic                 deg7_next;

    assign en       = !v_reg[NSTG-1] || stat.room;
    assign in_ready = en;
    assign push     = v_reg[NSTG-1] && stat.room;

    // edges: e1 = b - a, e2 = b - c
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            e1_next[i] = EW'($signed(in_data[(3+i)*CW +: CW]))
                       - EW'($signed(in_data[i*CW +: CW]));
            e2_next[i] = EW'($signed(in_data[(3+i)*CW +: CW]))
                       - EW'($signed(in_data[(6+i)*CW +: CW]));
        end
    end

    always_comb begin
        p_next[0] = e1_reg[1] * e2_reg[2];
        p_next[1] = e2_reg[1] * e1_reg[2];
        p_next[2] = e1_reg[2] * e2_reg[0];
        p_next[3] = e2_reg[2] * e1_reg[0];
        p_next[4] = e1_reg[0] * e2_reg[1];
        p_next[5] = e2_reg[0] * e1_reg[1];
    end

    always_comb begin
        logic signed [DW-1:0] d;
        for (int i = 0; i < 3; i++) begin
            d            = DW'(p_reg[2*i]) - DW'(p_reg[2*i+1]);
            neg3_next[i] = d[DW-1];
            mag_next[i]  = d[DW-1] ? MW'(-d) : MW'(d);
        end
    end

    // square of each magnitude from three half-width partial products
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            csq5_next[i] = (CSW'(hh_reg[i]) << (2 * HW))
                         + (CSW'(hl_reg[i]) << (HW + 1))
                         + CSW'(ll_reg[i]);
        end
    end

    assign s6_next   = SW'(csq5_reg[0]) + SW'(csq5_reg[1]) + SW'(csq5_reg[2]);
    assign deg7_next = (s6_reg < SW'(thr)) || (s6_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NSTG-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                e1_reg[i]   <= e1_next[i];
                e2_reg[i]   <= e2_next[i];
                mag_reg[i]  <= mag_next[i];
                hh_reg[i]   <= mag_reg[i][MW-1 -: HIW] * mag_reg[i][MW-1 -: HIW];
                hl_reg[i]   <= mag_reg[i][MW-1 -: HIW] * mag_reg[i][HW-1:0];
                ll_reg[i]   <= mag_reg[i][HW-1:0] * mag_reg[i][HW-1:0];
                csq5_reg[i] <= csq5_next[i];
                csq6_reg[i] <= csq5_reg[i];
                csq7_reg[i] <= csq6_reg[i];
            end
            for (int j = 0; j < 6; j++) begin
                p_reg[j] <= p_next[j];
            end
            neg3_reg <= neg3_next;
            neg4_reg <= neg3_reg;
            neg5_reg <= neg4_reg;
            neg6_reg <= neg5_reg;
            neg7_reg <= neg6_reg;
            s6_reg   <= s6_next;
            s7_reg   <= s6_reg;
            deg7_reg <= deg7_next;
        end
    end

    assign push_data = {deg7_reg, neg7_reg, s7_reg, csq7_reg[2], csq7_reg[1], csq7_reg[0]};

endmodule

>>> hw/rtl/tfn_back.sv
// tfn_back: per component division by the squared length, square root and rounding
// depends on tfn_pkg; drains tfn_fifo into the output register
module tfn_back #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  tfn_pkg::fifo_stat_t                         stat,
    input  logic [tfn_pkg::payload_w(COORD_WIDTH)-1:0] pop_data,
    output logic                                        pop,
    output logic                                        out_valid,
    input  logic                                        out_ready,
    output logic [3*tfn_pkg::OUT_W-1:0]                 out_data,
    output logic                                        out_deg
);

    localparam int CSW  = tfn_pkg::csq_w(COORD_WIDTH);
    localparam int SW   = tfn_pkg::sum_w(COORD_WIDTH);
    localparam int QW   = tfn_pkg::QUOT_W;
    localparam int RW   = tfn_pkg::ROOT_W;
    localparam int RADW = tfn_pkg::RAD_W;
    localparam int RMW  = tfn_pkg::REM_W;
    localparam int OW   = tfn_pkg::OUT_W;

    logic adv;

    // division pipeline: entry k holds the item after k quotient bits
    logic [QW:0]     dv_reg;
    logic [SW-1:0]   dr_reg  [0:QW][0:2];
    logic [QW-1:0]   dq_reg  [0:QW][0:2];
    logic [SW-1:0]   ds_reg  [0:QW];
    logic [2:0]      dn_reg  [0:QW];
    logic            dd_reg  [0:QW];
    logic [SW-1:0]   dr_next [0:QW-1][0:2];
    logic [QW-1:0]   dq_next [0:QW-1][0:2];

    // root pipeline: entry i holds the item after i root bits
    logic [RW:0]     sv_reg;
    logic [RADW-1:0] srad_reg  [0:RW][0:2];
    logic [RMW-1:0]  srem_reg  [0:RW][0:2];
    logic [RW-1:0]   sroot_reg [0:RW][0:2];
    logic [2:0]      sn_reg    [0:RW];
    logic            sd_reg    [0:RW];
    logic [RMW-1:0]  srem_next [0:RW-1][0:2];
    logic [RW-1:0]   sroot_next[0:RW-1][0:2];

    logic            out_valid_reg;
    logic [3*OW-1:0] out_data_reg;
    logic [3*OW-1:0] out_data_next;
    logic            out_deg_reg;

    assign adv       = !out_valid_reg || out_ready;
    assign pop       = adv && !stat.empty;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_deg   = out_deg_reg;

    // restoring division, one quotient bit per stage: q = floor(c^2 * 2^30 / s)
    for (genvar k = 0; k < QW; k++) begin : g_div
        for (genvar l = 0; l < 3; l++) begin : g_lane
            logic [SW:0] t;
            logic        ge;
            if (k == 0) begin : g_first
                assign t = {1'b0, dr_reg[k][l]};
            end else begin : g_shift
                assign t = {dr_reg[k][l], 1'b0};
            end
            assign ge            = (t >= {1'b0, ds_reg[k]});
            assign dr_next[k][l] = ge ? SW'(t - {1'b0, ds_reg[k]}) : SW'(t);
            assign dq_next[k][l] = {dq_reg[k][l][QW-2:0], ge};
        end
    end

    // digit by digit integer square root, two radicand bits per stage
    for (genvar i = 0; i < RW; i++) begin : g_root
        for (genvar l = 0; l < 3; l++) begin : g_lane
            logic [RMW-1:0] rem_sh;
            logic [RMW-1:0] trial;
            logic           ge;
            assign rem_sh           = {srem_reg[i][l][RMW-3:0], srad_reg[i][l][RADW-1 -: 2]};
            assign trial            = {sroot_reg[i][l], 2'b01};
            assign ge               = (rem_sh >= trial);
            assign srem_next[i][l]  = ge ? (rem_sh - trial) : rem_sh;
            assign sroot_next[i][l] = {sroot_reg[i][l][RW-2:0], ge};
        end
    end

    // round: largest m with (2m-1)^2 <= q is (isqrt(q) + 1) / 2
    always_comb begin
        logic [RW:0]   m_full;
        logic [OW-1:0] m;
        for (int l = 0; l < 3; l++) begin
            m_full = {1'b0, sroot_reg[RW][l]} + 1'b1;
            m      = OW'(m_full[RW:1]);
            if (sd_reg[RW]) begin
                out_data_next[l*OW +: OW] = '0;
            end else if (sn_reg[RW][l]) begin
                out_data_next[l*OW +: OW] = -m;
            end else begin
                out_data_next[l*OW +: OW] = m;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg        <= '0;
            sv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            dv_reg        <= {dv_reg[QW-1:0], pop};
            sv_reg        <= {sv_reg[RW-1:0], dv_reg[QW]};
            out_valid_reg <= sv_reg[RW];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int l = 0; l < 3; l++) begin
                dr_reg[0][l]    <= SW'(pop_data[l*CSW +: CSW]);
                dq_reg[0][l]    <= '0;
                srad_reg[0][l]  <= RADW'(dq_reg[QW][l]);
                srem_reg[0][l]  <= '0;
                sroot_reg[0][l] <= '0;
            end
            ds_reg[0] <= pop_data[3*CSW +: SW];
            dn_reg[0] <= pop_data[3*CSW+SW +: 3];
            dd_reg[0] <= pop_data[3*CSW+SW+3];
            for (int k = 0; k < QW; k++) begin
                for (int l = 0; l < 3; l++) begin
                    dr_reg[k+1][l] <= dr_next[k][l];
                    dq_reg[k+1][l] <= dq_next[k][l];
                end
                ds_reg[k+1] <= ds_reg[k];
                dn_reg[k+1] <= dn_reg[k];
                dd_reg[k+1] <= dd_reg[k];
            end
            sn_reg[0] <= dn_reg[QW];
            sd_reg[0] <= dd_reg[QW];
            for (int i = 0; i < RW; i++) begin
                for (int l = 0; l < 3; l++) begin
                    srad_reg[i+1][l]  <= {srad_reg[i][l][RADW-3:0], 2'b00};
                    srem_reg[i+1][l]  <= srem_next[i][l];
                    sroot_reg[i+1][l] <= sroot_next[i][l];
                end
                sn_reg[i+1] <= sn_reg[i];
                sd_reg[i+1] <= sd_reg[i];
            end
            out_data_reg <= out_data_next;
            out_deg_reg  <= sd_reg[RW];
        end
    end

endmodule

>>> hw/rtl/triangle_face_normal_top.sv
// triangle_face_normal_top: unit surface normal of a triangle from its three vertices
// depends on tfn_pkg, tfn_front, tfn_fifo and tfn_back
//
// Takes one triangle (three signed Q8.8 vertices) per transaction and returns its unit
// normal (b-a) x (b-c) in signed Q1.14, rounded to nearest with ties away from zero.
// A triangle whose squared normal length (units 2^-32) is below the threshold thr_reg, or
// is zero, returns a zero vector with the degenerate flag set. The block sustains one
// triangle per clock while the output is not stalled. Its path runs through the 7-stage
// geometry front end, the queue, the 32 register ranks of the quotient pipeline (31
// quotient bits) and the 17 ranks of the square root pipeline (16 root bits), plus the
// output register. The threshold register resets to 429 and is written through the cfg
// port; the user must write it only while idle, which the block does not enforce.
module triangle_face_normal_top #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, zero pad to bytes
    input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // normal_x, normal_y, normal_z
    output logic [3*tfn_pkg::OUT_W-1:0]       m_tdata,
    // degenerate
    output logic                              m_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tfn_pkg::THR_W-1:0]         cfg_data
);

    localparam int PLW = tfn_pkg::payload_w(COORD_WIDTH);
    localparam int OW  = tfn_pkg::OUT_W;

    logic [tfn_pkg::THR_W-1:0] thr_reg;
    tfn_pkg::fifo_stat_t       stat;
    logic                      push;
    logic                      pop;
    logic [PLW-1:0]            push_data;
    logic [PLW-1:0]            pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= tfn_pkg::THR_RESET;
        end else if (cfg_valid && cfg_ready) begin
            thr_reg <= cfg_data;
        end
    end

    tfn_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata[9*COORD_WIDTH-1:0]),
        .thr       (thr_reg),
        .stat      (stat),
        .push      (push),
        .push_data (push_data)
    );

    tfn_fifo #(
        .DATA_W (PLW)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (stat)
    );

    tfn_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .stat      (stat),
        .pop_data  (pop_data),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_deg   (m_tuser)
    );

    a_deg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("degenerate result with nonzero normal");

    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |->
            ($signed(m_tdata[0 +: OW]) <= tfn_pkg::UNIT_ONE)
            && ($signed(m_tdata[0 +: OW]) >= -tfn_pkg::UNIT_ONE)
            && ($signed(m_tdata[OW +: OW]) <= tfn_pkg::UNIT_ONE)
            && ($signed(m_tdata[OW +: OW]) >= -tfn_pkg::UNIT_ONE)
            && ($signed(m_tdata[2*OW +: OW]) <= tfn_pkg::UNIT_ONE)
            && ($signed(m_tdata[2*OW +: OW]) >= -tfn_pkg::UNIT_ONE))
        else $error("normal component outside unit range");

endmodule
